@@ rtl/owbm_pkg.sv @@
// Package for the 1-Wire bus master: payload types, register map, phase and action codes.
package owbm_pkg;

    localparam int TIMER_BITS = 10;
    localparam int CFG_W      = 10;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = TIMER_BITS'((1 << TIMER_BITS) - 1);

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_value;
        logic       line_level;
    } owbm_item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       bus_error;
        logic [7:0] byte_read;
    } owbm_result_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low_time;
        logic [CFG_W-1:0] presence_sample_time;
        logic [CFG_W-1:0] reset_recovery_time;
        logic [CFG_W-1:0] slot_low_time;
        logic [CFG_W-1:0] slot_sample_time;
        logic [CFG_W-1:0] slot_rest_time;
    } owbm_cfg_t;

    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_PRESENCE_SMP  = 3'd1;
    localparam logic [2:0] REG_RESET_RECOV   = 3'd2;
    localparam logic [2:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [2:0] REG_SLOT_SAMPLE   = 3'd4;
    localparam logic [2:0] REG_SLOT_REST     = 3'd5;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_RESET = 2'd1;
    localparam logic [1:0] ACT_BYTE  = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_RST_LOW   = 7'b0000010,
        PH_RST_WAIT  = 7'b0000100,
        PH_RST_RECOV = 7'b0001000,
        PH_SLOT_LOW  = 7'b0010000,
        PH_SLOT_WAIT = 7'b0100000,
        PH_SLOT_REST = 7'b1000000
    } owbm_phase_t;

    function automatic logic [TIMER_BITS-1:0] load_time(input logic [CFG_W-1:0] t);
        logic [16:0] w;
        w = 17'(t);
        if (w > 17'(TIMER_MAX))
            return TIMER_MAX;
        else
            return TIMER_BITS'(w);
    endfunction

endpackage

@@ rtl/one_wire_bus_master.sv @@
// Top level of the 1-Wire bus master: input register, sequencer, result register, config port.
// Each beat on the item channel is one microsecond tick carrying an action and the sampled
// line level; each such beat yields exactly one result beat with the line drive, busy, done,
// error flag and the byte read. The block takes one beat per clock while the result side
// keeps up: an input register feeds the sequencer, whose step logic fills a result register.
// Timing registers must be written through the config port only while no operation is
// running; the block itself does not enforce this.
module one_wire_bus_master
    import owbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  owbm_item_t       item_data,
    output logic             result_valid,
    input  logic             result_stall,
    output owbm_result_t     result_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    owbm_item_t   in_reg;
    logic         in_vld_reg, in_vld_next;
    owbm_result_t out_reg;
    logic         out_vld_reg, out_vld_next;
    owbm_result_t step_res;
    owbm_cfg_t    cfg;
    logic         adv;
    logic         step_en;
    logic         take;

    owbm_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    owbm_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    assign adv          = ~out_vld_reg | ~result_stall;
    assign step_en      = in_vld_reg & adv;
    assign item_stall   = in_vld_reg & ~adv;
    assign take         = item_valid & ~item_stall;
    assign result_valid = out_vld_reg;
    assign result_data  = out_reg;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
            in_vld_next = 1'b1;
        else if (step_en)
            in_vld_next = 1'b0;
        out_vld_next = adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            in_reg <= item_data;
        if (step_en)
            out_reg <= step_res;
    end

endmodule

@@ rtl/owbm_cfg_regs.sv @@
// Timing configuration registers of the 1-Wire bus master.
module owbm_cfg_regs
    import owbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output owbm_cfg_t        cfg
);

    owbm_cfg_t cfg_reg;
    owbm_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_RESET_LOW:    cfg_next.reset_low_time       = cfg_data;
                REG_PRESENCE_SMP: cfg_next.presence_sample_time = cfg_data;
                REG_RESET_RECOV:  cfg_next.reset_recovery_time  = cfg_data;
                REG_SLOT_LOW:     cfg_next.slot_low_time        = cfg_data;
                REG_SLOT_SAMPLE:  cfg_next.slot_sample_time     = cfg_data;
                REG_SLOT_REST:    cfg_next.slot_rest_time       = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low_time       <= CFG_W'(400);
            cfg_reg.presence_sample_time <= CFG_W'(66);
            cfg_reg.reset_recovery_time  <= CFG_W'(414);
            cfg_reg.slot_low_time        <= CFG_W'(1);
            cfg_reg.slot_sample_time     <= CFG_W'(9);
            cfg_reg.slot_rest_time       <= CFG_W'(45);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/owbm_core.sv @@
// Bus sequencer: phase, tick counter, shift byte, bit count and error flag, one step per tick.
module owbm_core
    import owbm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step_en,
    input  owbm_item_t   item,
    input  owbm_cfg_t    cfg,
    output owbm_result_t result
);

    owbm_phase_t           phase_reg, phase_next;
    logic [TIMER_BITS-1:0] tick_reg, tick_next;
    logic [7:0]            shift_reg, shift_next;
    logic [3:0]            bits_reg, bits_next;
    logic                  err_reg, err_next;
    logic                  sdrive_reg, sdrive_next;
    logic                  drive;
    logic                  done;
    logic [7:0]            rd;
    logic                  rbit;

    always_comb
    begin
        phase_next  = phase_reg;
        tick_next   = tick_reg;
        shift_next  = shift_reg;
        bits_next   = bits_reg;
        err_next    = err_reg;
        sdrive_next = sdrive_reg;
        drive       = 1'b0;
        done        = 1'b0;
        rd          = 8'h00;
        rbit        = shift_reg[0] & item.line_level;

        if (phase_reg == PH_IDLE)
        begin
            case (item.action)
                ACT_RESET:
                begin
                    phase_next = PH_RST_LOW;
                    tick_next  = load_time(cfg.reset_low_time);
                    drive      = 1'b1;
                end
                ACT_BYTE:
                begin
                    shift_next = item.byte_value;
                    bits_next  = 4'd8;
                    phase_next = PH_SLOT_LOW;
                    tick_next  = load_time(cfg.slot_low_time);
                    drive      = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else if (tick_reg > TIMER_BITS'(1))
        begin
            tick_next = tick_reg - TIMER_BITS'(1);
            if (phase_reg inside {PH_RST_LOW, PH_SLOT_LOW})
                drive = 1'b1;
            else if (phase_reg inside {PH_SLOT_WAIT, PH_SLOT_REST})
                drive = sdrive_reg;
        end
        else
        begin
            case (phase_reg)
                PH_RST_LOW:
                begin
                    phase_next = PH_RST_WAIT;
                    tick_next  = load_time(cfg.presence_sample_time);
                end
                PH_RST_WAIT:
                begin
                    err_next   = item.line_level;
                    phase_next = PH_RST_RECOV;
                    tick_next  = load_time(cfg.reset_recovery_time);
                end
                PH_RST_RECOV:
                begin
                    if (!item.line_level)
                        err_next = 1'b1;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    done       = 1'b1;
                end
                PH_SLOT_LOW:
                begin
                    sdrive_next = ~shift_reg[0];
                    drive       = ~shift_reg[0];
                    phase_next  = PH_SLOT_WAIT;
                    tick_next   = load_time(cfg.slot_sample_time);
                end
                PH_SLOT_WAIT:
                begin
                    shift_next = {rbit, shift_reg[7:1]};
                    drive      = sdrive_reg;
                    phase_next = PH_SLOT_REST;
                    tick_next  = load_time(cfg.slot_rest_time);
                end
                PH_SLOT_REST:
                begin
                    sdrive_next = 1'b0;
                    bits_next   = (bits_reg != 4'd0) ? bits_reg - 4'd1 : 4'd0;
                    if (bits_next == 4'd0)
                    begin
                        phase_next = PH_IDLE;
                        tick_next  = '0;
                        done       = 1'b1;
                        rd         = shift_reg;
                    end
                    else
                    begin
                        phase_next = PH_SLOT_LOW;
                        tick_next  = load_time(cfg.slot_low_time);
                        drive      = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            endcase
        end
    end

    assign result.drive_low = drive;
    assign result.busy_res  = (phase_next != PH_IDLE);
    assign result.done_res  = done;
    assign result.bus_error = err_next;
    assign result.byte_read = rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            tick_reg   <= '0;
            shift_reg  <= 8'h00;
            bits_reg   <= 4'd0;
            err_reg    <= 1'b0;
            sdrive_reg <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg  <= phase_next;
            tick_reg   <= tick_next;
            shift_reg  <= shift_next;
            bits_reg   <= bits_next;
            err_reg    <= err_next;
            sdrive_reg <= sdrive_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0))
        else $error("timer not cleared in idle");

    a_bits_range: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= 4'd8)
        else $error("bit count out of range");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && result.done_res) |-> !result.busy_res)
        else $error("done while still busy");

    a_byte_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && (result.byte_read != 8'h00)) |-> result.done_res)
        else $error("read byte shown without done");

    a_slot_drive_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> !sdrive_reg)
        else $error("slot drive left on in idle");
`endif

endmodule

@@ tb/sv/one_wire_bus_master_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the 1-Wire bus master: tick predictor, scoreboard and drivers.
module one_wire_bus_master_test;
    import owbm_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TOTAL_ITEMS = 950;
    localparam int PHASE_ITEMS = 120;
    localparam logic [1:0] ACT_SPARE = 2'd3;

    typedef enum int {LINE_RANDOM, LINE_HIGH, LINE_LOW, LINE_SLAVE} line_mode_t;

    class bus_master_scoreboard;
        owbm_cfg_t timing;
        owbm_phase_t seq_phase;
        logic [TIMER_BITS-1:0] ticks;
        logic [7:0] shift_byte;
        logic [3:0] bits_left;
        logic error_flag;
        logic slot_drive;
        owbm_result_t expected_results[$];
        int failures;

        function new();
            timing.reset_low_time = 400;
            timing.presence_sample_time = 66;
            timing.reset_recovery_time = 414;
            timing.slot_low_time = 1;
            timing.slot_sample_time = 9;
            timing.slot_rest_time = 45;
            seq_phase = PH_IDLE;
            ticks = '0;
            shift_byte = '0;
            bits_left = '0;
            error_flag = 1'b0;
            slot_drive = 1'b0;
            failures = 0;
        endfunction

        function void write_reg(logic [2:0] index, logic [CFG_W-1:0] value);
            case (index)
                REG_RESET_LOW:    timing.reset_low_time = value;
                REG_PRESENCE_SMP: timing.presence_sample_time = value;
                REG_RESET_RECOV:  timing.reset_recovery_time = value;
                REG_SLOT_LOW:     timing.slot_low_time = value;
                REG_SLOT_SAMPLE:  timing.slot_sample_time = value;
                REG_SLOT_REST:    timing.slot_rest_time = value;
                default: ;
            endcase
        endfunction

        function logic [TIMER_BITS-1:0] timer_of(logic [CFG_W-1:0] t);
            if (t > TIMER_MAX)
                return TIMER_MAX;
            return TIMER_BITS'(t);
        endfunction

        function owbm_result_t advance_sequencer(owbm_item_t it);
            owbm_result_t r;
            logic drive;
            logic done;
            logic rd_bit;
            logic [7:0] rd;
            drive = 1'b0;
            done = 1'b0;
            rd = '0;
            if (seq_phase == PH_IDLE)
            begin
                if (it.action == ACT_RESET)
                begin
                    seq_phase = PH_RST_LOW;
                    ticks = timer_of(timing.reset_low_time);
                    drive = 1'b1;
                end
                else if (it.action == ACT_BYTE)
                begin
                    shift_byte = it.byte_value;
                    bits_left = 4'd8;
                    seq_phase = PH_SLOT_LOW;
                    ticks = timer_of(timing.slot_low_time);
                    drive = 1'b1;
                end
            end
            else if (ticks > 1)
            begin
                ticks = ticks - 1'b1;
                if (seq_phase == PH_RST_LOW || seq_phase == PH_SLOT_LOW)
                    drive = 1'b1;
                else if (seq_phase == PH_SLOT_WAIT || seq_phase == PH_SLOT_REST)
                    drive = slot_drive;
            end
            else
            begin
                case (seq_phase)
                    PH_RST_LOW:
                    begin
                        seq_phase = PH_RST_WAIT;
                        ticks = timer_of(timing.presence_sample_time);
                    end
                    PH_RST_WAIT:
                    begin
                        error_flag = it.line_level;
                        seq_phase = PH_RST_RECOV;
                        ticks = timer_of(timing.reset_recovery_time);
                    end
                    PH_RST_RECOV:
                    begin
                        if (!it.line_level)
                            error_flag = 1'b1;
                        seq_phase = PH_IDLE;
                        ticks = '0;
                        done = 1'b1;
                    end
                    PH_SLOT_LOW:
                    begin
                        slot_drive = ~shift_byte[0];
                        drive = slot_drive;
                        seq_phase = PH_SLOT_WAIT;
                        ticks = timer_of(timing.slot_sample_time);
                    end
                    PH_SLOT_WAIT:
                    begin
                        rd_bit = shift_byte[0] & it.line_level;
                        shift_byte = {rd_bit, shift_byte[7:1]};
                        drive = slot_drive;
                        seq_phase = PH_SLOT_REST;
                        ticks = timer_of(timing.slot_rest_time);
                    end
                    PH_SLOT_REST:
                    begin
                        slot_drive = 1'b0;
                        if (bits_left != 0)
                            bits_left = bits_left - 1'b1;
                        if (bits_left == 0)
                        begin
                            seq_phase = PH_IDLE;
                            ticks = '0;
                            done = 1'b1;
                            rd = shift_byte;
                        end
                        else
                        begin
                            seq_phase = PH_SLOT_LOW;
                            ticks = timer_of(timing.slot_low_time);
                            drive = 1'b1;
                        end
                    end
                    default:
                    begin
                        seq_phase = PH_IDLE;
                        ticks = '0;
                    end
                endcase
            end
            r.drive_low = drive;
            r.busy_res = (seq_phase != PH_IDLE);
            r.done_res = done;
            r.bus_error = error_flag;
            r.byte_read = rd;
            return r;
        endfunction

        function void note_tick(owbm_item_t it);
            expected_results.push_back(advance_sequencer(it));
        endfunction

        function void compare_field(string name, int exp_val, int got_val);
            if (exp_val != got_val)
            begin
                $error("%s: expected %0h, got %0h", name, exp_val, got_val);
                failures++;
            end
        endfunction

        function void check_result(owbm_result_t got);
            owbm_result_t exp_r;
            if (expected_results.size() == 0)
            begin
                $error("result beat with nothing expected: %0h", got);
                failures++;
                return;
            end
            exp_r = expected_results.pop_front();
            compare_field("drive_low", exp_r.drive_low, got.drive_low);
            compare_field("busy_res", exp_r.busy_res, got.busy_res);
            compare_field("done_res", exp_r.done_res, got.done_res);
            compare_field("bus_error", exp_r.bus_error, got.bus_error);
            compare_field("byte_read", exp_r.byte_read, got.byte_read);
        endfunction

        function void flush_leftover();
            if (expected_results.size() != 0)
            begin
                $error("%0d expected result beats never arrived", expected_results.size());
                failures++;
            end
        endfunction

        function bit is_idle();
            return seq_phase == PH_IDLE;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    owbm_item_t item_data;
    logic result_valid;
    logic result_stall = 1'b0;
    owbm_result_t result_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    bus_master_scoreboard sb;
    int items_sent = 0;
    int burst_left = 0;
    int gap_max = 0;
    int stall_pct = 0;
    int stall_left = 0;
    int cycle_count = 0;

    one_wire_bus_master u_top (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .item_data(item_data),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result_data(result_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result side: check accepted beats, stall in stretches of varying density
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_result(result_data);
        if (stall_left == 0)
        begin
            stall_left = $urandom_range(32, 256);
            case ($urandom_range(0, 4))
                0, 1: stall_pct = 0;
                2: stall_pct = 15;
                3: stall_pct = 40;
                default: stall_pct = 70;
            endcase
        end
        stall_left--;
        result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    function automatic logic pick_line(line_mode_t mode);
        case (mode)
            LINE_HIGH: return 1'b1;
            LINE_LOW: return 1'b0;
            LINE_SLAVE:
            begin
                // presence pulse while waiting, bus released during recovery
                if (sb.seq_phase == PH_RST_WAIT)
                    return 1'b0;
                if (sb.seq_phase == PH_RST_RECOV)
                    return 1'b1;
                return 1'($urandom_range(0, 1));
            end
            default: return 1'($urandom_range(0, 1));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [7:0] bval,
                             input line_mode_t mode);
        owbm_item_t it;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            if (gap_max > 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
            end
        end
        burst_left--;
        it.action = act;
        it.byte_value = bval;
        it.line_level = pick_line(mode);
        item_valid <= 1'b1;
        item_data <= it;
        do @(posedge clk); while (item_stall);
        sb.note_tick(it);
        items_sent++;
    endtask

    // start an operation and tick until it completes; noise injects actions while busy
    task automatic run_op(input logic [1:0] act, input logic [7:0] bval,
                          input line_mode_t mode, input int noise);
        logic [1:0] busy_act;
        send_item(act, bval, mode);
        while (!sb.is_idle())
        begin
            busy_act = ($urandom_range(0, 99) < noise) ? 2'($urandom_range(0, 3)) : ACT_TICK;
            send_item(busy_act, 8'($urandom), mode);
        end
    endtask

    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input owbm_cfg_t c);
        logic [2:0] regs[6];
        logic [CFG_W-1:0] vals[6];
        regs = '{REG_RESET_LOW, REG_PRESENCE_SMP, REG_RESET_RECOV,
                 REG_SLOT_LOW, REG_SLOT_SAMPLE, REG_SLOT_REST};
        vals = '{c.reset_low_time, c.presence_sample_time, c.reset_recovery_time,
                 c.slot_low_time, c.slot_sample_time, c.slot_rest_time};
        for (int i = 0; i < 6; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            do @(posedge clk); while (!cfg_ready);
            sb.write_reg(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] random_time();
        if ($urandom_range(0, 99) < 90)
            return CFG_W'($urandom_range(0, 6));
        return CFG_W'($urandom_range(7, 60));
    endfunction

    function automatic owbm_cfg_t random_timing();
        owbm_cfg_t c;
        c.reset_low_time = random_time();
        c.presence_sample_time = random_time();
        c.reset_recovery_time = random_time();
        c.slot_low_time = random_time();
        c.slot_sample_time = random_time();
        c.slot_rest_time = random_time();
        return c;
    endfunction

    initial
    begin
        owbm_cfg_t c;
        int phase_end;
        int roll;
        line_mode_t mode;
        int noise;
        logic [7:0] bval;

        sb = new();
        rst_n <= 1'b0;
        item_valid <= 1'b0;
        item_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_RESET_LOW;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-on slot timing
        run_op(ACT_BYTE, 8'hFF, LINE_RANDOM, 0);
        settle();

        // shortest legal timing
        c = '{default: CFG_W'(1)};
        write_config(c);
        gap_max = 3;
        send_item(ACT_TICK, 8'hFF, LINE_RANDOM);
        send_item(ACT_SPARE, 8'h00, LINE_RANDOM);
        run_op(ACT_RESET, 8'hFF, LINE_SLAVE, 0);
        run_op(ACT_RESET, 8'h00, LINE_HIGH, 0);
        run_op(ACT_RESET, 8'h00, LINE_LOW, 0);
        // error flag must survive byte transfers
        run_op(ACT_BYTE, 8'h00, LINE_HIGH, 0);
        run_op(ACT_BYTE, 8'hFF, LINE_HIGH, 0);
        run_op(ACT_BYTE, 8'hFF, LINE_LOW, 0);
        run_op(ACT_BYTE, 8'hA5, LINE_RANDOM, 0);
        run_op(ACT_BYTE, 8'h5A, LINE_RANDOM, 100);
        run_op(ACT_RESET, 8'h00, LINE_SLAVE, 100);
        run_op(ACT_BYTE, 8'h3C, LINE_HIGH, 0);
        settle();

        // zero times behave as one tick
        c = '{default: CFG_W'(0)};
        write_config(c);
        run_op(ACT_RESET, 8'h00, LINE_SLAVE, 0);
        run_op(ACT_BYTE, 8'h96, LINE_RANDOM, 0);
        settle();

        while (items_sent < TOTAL_ITEMS)
        begin
            write_config(random_timing());
            case ($urandom_range(0, 2))
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 8;
            endcase
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < TOTAL_ITEMS)
            begin
                roll = $urandom_range(0, 99);
                mode = ($urandom_range(0, 99) < 70) ? LINE_SLAVE
                                                    : line_mode_t'($urandom_range(0, 2));
                noise = ($urandom_range(0, 99) < 20) ? 30 : 0;
                bval = ($urandom_range(0, 99) < 30) ? 8'hFF : 8'($urandom);
                if (roll < 45)
                    run_op(ACT_RESET, bval, mode, noise);
                else if (roll < 90)
                    run_op(ACT_BYTE, bval, mode, noise);
                else
                    repeat ($urandom_range(1, 5))
                        send_item(($urandom_range(0, 1) != 0) ? ACT_TICK : ACT_SPARE,
                                  8'($urandom), LINE_RANDOM);
            end
            settle();
        end

        repeat (10) @(posedge clk);
        sb.flush_leftover();
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/owbm_pkg.sv
rtl/owbm_cfg_regs.sv
rtl/owbm_core.sv
rtl/one_wire_bus_master.sv
tb/sv/one_wire_bus_master_test.sv
